@@ sv/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // request operations
  typedef enum logic [2:0] {
    M_PUSH_FRONT = 3'd0,
    M_PUSH_BACK  = 3'd1,
    M_POP_FRONT  = 3'd2,
    M_POP_BACK   = 3'd3,
    M_INSERT     = 3'd4,
    M_SEARCH     = 3'd5
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BOUNDS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_sel_t;

  // per-cell control from the list controller
  typedef struct packed {
    cell_sel_t           sel;
    logic [DATA_W-1:0]   value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/ordered_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of signed 32-bit values held in a row of shifting cells.
// ----------------------------------------------------------------------------
// The engine takes one request transaction per clock while in_stall is low,
// and returns one result transaction per request, registered in the cycle
// after acceptance. Every operation (push, pop, insert, search) is decided
// on acceptance: all cells of the row shift or compare at once, and one
// output register sits between the cell row and the result port, so a new
// request is taken while a result waits if the result is taken in the same
// cycle. After reset the list is empty and requests are taken right away.
`default_nettype none

module ordered_list_engine_top
  import ole_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        mode,
  input  wire logic signed [31:0] value,
  input  wire logic [4:0]        position,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [3:0]             found_position,
  output logic [4:0]             length
);

  logic                count;
  logic [CNT_W-1:0]    count_q;
  logic [CNT_W-1:0]    count_next;
  logic                accept;
  logic [CNT_W-1:0]    place_pos;
  logic                is_place;
  logic                place_ok;
  logic                head_pop_ok;
  logic                tail_pop_ok;
  status_t             status_next;
  logic [IDX_W-1:0]    found_next;
  logic [CAPACITY-1:0] hit;
  logic [DATA_W-1:0]   cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_ctrl_t          cell_ctrl [CAPACITY];

  // handshake: hold off while reset or while a result is stuck
  assign in_stall = rst || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign count    = (count_q == CNT_W'(CAPACITY));

  // request decode
  always_comb begin
    place_pos   = '0;
    is_place    = 1'b0;
    head_pop_ok = 1'b0;
    tail_pop_ok = 1'b0;
    status_next = ST_OK;
    unique case (mode)
      M_PUSH_FRONT: begin
        is_place  = 1'b1;
        place_pos = '0;
      end
      M_PUSH_BACK: begin
        is_place  = 1'b1;
        place_pos = count_q;
      end
      M_INSERT: begin
        is_place  = 1'b1;
        place_pos = position;
      end
      M_POP_FRONT: begin
        if (count_q == '0) status_next = ST_EMPTY;
        else               head_pop_ok = 1'b1;
      end
      M_POP_BACK: begin
        if (count_q == '0) status_next = ST_EMPTY;
        else               tail_pop_ok = 1'b1;
      end
      M_SEARCH: begin
        status_next = (hit != '0) ? ST_OK : ST_NOTFOUND;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
    // bounds check ahead of full check
    place_ok = 1'b0;
    if (is_place) begin
      priority if (place_pos > count_q) status_next = ST_BOUNDS;
      else if (count)                   status_next = ST_FULL;
      else                              place_ok = 1'b1;
    end
  end

  // length after the operation
  always_comb begin
    priority if (place_ok)                   count_next = count_q + CNT_W'(1);
    else if (head_pop_ok || tail_pop_ok)     count_next = count_q - CNT_W'(1);
    else                                     count_next = count_q;
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;
    localparam int LEFT  = (i == 0) ? 0 : i - 1;

    // per-cell action
    always_comb begin
      cell_ctrl[i].value = value;
      cell_ctrl[i].sel   = CELL_HOLD;
      if (accept) begin
        priority if (place_ok && (CNT_W'(i) == place_pos)) cell_ctrl[i].sel = CELL_LOAD;
        else if (place_ok && (CNT_W'(i) > place_pos))      cell_ctrl[i].sel = CELL_FROM_LEFT;
        else if (head_pop_ok)                              cell_ctrl[i].sel = CELL_FROM_RIGHT;
        else                                               cell_ctrl[i].sel = CELL_HOLD;
      end
    end

    ole_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .left_data  (cell_data[LEFT]),
      .right_data (cell_data[RIGHT]),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );

    // only occupied slots count as hits
    assign hit[i] = cell_match[i] && (CNT_W'(i) < count_q);
  end

  // first hit from the front
  always_comb begin
    found_next = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) found_next = IDX_W'(i);
    end
  end

  // list length register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      status         <= status_next;
      found_position <= ((mode == M_SEARCH) && (hit != '0)) ? found_next : '0;
      length         <= count_next;
    end
  end

  // length never exceeds the row
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length <= CNT_W'(CAPACITY)))
    else $error("length beyond capacity");

  // successful search points inside the list
  a_found_in_list: assert property (@(posedge clk) disable iff (rst)
    ($past(accept) && ($past(mode) == M_SEARCH) && (status == ST_OK))
      |-> (CNT_W'(found_position) < length))
    else $error("found position outside list");

  // successful pop shortens the list by one
  a_pop_len: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == M_POP_FRONT || mode == M_POP_BACK) && (count_q != '0))
      |=> (length == $past(count_q) - CNT_W'(1)))
    else $error("pop did not shorten list");

  // a rejected placement leaves the length alone
  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && is_place && !place_ok) |=> (count_q == $past(count_q)))
    else $error("rejected placement changed length");

endmodule

`default_nettype wire

@@ sv/ole_cell.sv @@
// ----------------------------------------------------------------------------
// ole_cell
// One slot of the list: holds a value, loads, or takes a neighbor's value,
// and compares its contents against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_cell
  import ole_pkg::*;
(
  input  wire logic              clk,
  input  wire cell_ctrl_t        ctrl,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic                   match
);

  logic [DATA_W-1:0] data_next;

  // next contents of the slot
  always_comb begin
    unique case (ctrl.sel)
      CELL_HOLD:       data_next = data;
      CELL_LOAD:       data_next = ctrl.value;
      CELL_FROM_LEFT:  data_next = left_data;
      CELL_FROM_RIGHT: data_next = right_data;
      default:         data_next = data;
    endcase
  end

  // slot storage, undefined until written
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // key compare
  assign match = (data == ctrl.value);

endmodule

`default_nettype wire
